/* src/dtlv_pkg.sv */
// Shared types and constants of the DER TLV header parser.
package dtlv_pkg;

	localparam int OFFSET_BITS_DEF      = 32;
	localparam int MAX_LENGTH_BYTES_DEF = 4;

	localparam int FIELD_BITS   = 32;
	localparam int CFG_DATA_W   = 32;
	localparam int CFG_INDEX_W  = 1;
	localparam int ERR_W        = 3;

	localparam logic [CFG_INDEX_W-1:0] CFG_PARSE_LIMIT = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_BUFFER_SIZE = 1'b1;

	localparam logic [CFG_DATA_W-1:0] CFG_RESET_VALUE = 32'hFFFF_FFFF;

	localparam int LONG_FORM_BIT = 7;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_FIRST,
		PH_LONG
	} phase_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE     = 3'd0,
		ERR_OFFSET   = 3'd1,
		ERR_COUNT    = 3'd2,
		ERR_LENBYTES = 3'd3,
		ERR_OVERFLOW = 3'd4,
		ERR_VALUE    = 3'd5
	} err_t;

	typedef struct packed {
		phase_t phase;
		logic   emit;
		logic   ok;
		err_t   err;
	} step_ctl_t;

endpackage

/* src/dtlv_if.sv */
// Handshake channels of the DER TLV header parser: header bytes in, results out.
interface dtlv_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  byte_value;
	logic        header_start;
	logic [31:0] start_offset;

	modport source(output valid, byte_value, header_start, start_offset, input ready);
	modport sink(input valid, byte_value, header_start, start_offset, output ready);
endinterface

interface dtlv_out_if;
	logic        valid;
	logic        ready;
	logic        ok;
	logic [2:0]  error_code;
	logic [7:0]  tag_byte;
	logic [31:0] body_offset;
	logic [31:0] body_length;
	logic [31:0] follow_offset;

	modport source(output valid, ok, error_code, tag_byte, body_offset, body_length,
		follow_offset, input ready);
	modport sink(input valid, ok, error_code, tag_byte, body_offset, body_length,
		follow_offset, output ready);
endinterface

/* src/dtlv_step.sv */
// Per-byte decode step: next parser state and the result the byte produces.
module dtlv_step #(
	parameter int OFFSET_BITS      = dtlv_pkg::OFFSET_BITS_DEF,
	parameter int MAX_LENGTH_BYTES = dtlv_pkg::MAX_LENGTH_BYTES_DEF,
	localparam int LEFT_W          = $clog2(MAX_LENGTH_BYTES + 1)
) (
	input  logic [7:0]                      byte_value,
	input  logic                            header_start,
	input  logic [dtlv_pkg::FIELD_BITS-1:0] start_offset,
	input  logic [OFFSET_BITS-1:0]          limit,
	input  dtlv_pkg::phase_t                phase,
	input  logic [OFFSET_BITS-1:0]          position,
	input  logic [7:0]                      held_tag,
	input  logic [LEFT_W-1:0]               bytes_left,
	input  logic [OFFSET_BITS-1:0]          length_accum,
	output dtlv_pkg::step_ctl_t             ctl,
	output logic [OFFSET_BITS-1:0]          position_nxt,
	output logic [7:0]                      held_tag_nxt,
	output logic [LEFT_W-1:0]               bytes_left_nxt,
	output logic [OFFSET_BITS-1:0]          length_accum_nxt,
	output logic [7:0]                      res_tag,
	output logic [OFFSET_BITS-1:0]          res_body_offset,
	output logic [OFFSET_BITS-1:0]          res_body_length,
	output logic [OFFSET_BITS-1:0]          res_follow_offset
);
	import dtlv_pkg::*;

	logic [OFFSET_BITS-1:0] start_pos;
	logic [OFFSET_BITS-1:0] pos_inc;
	logic [OFFSET_BITS-1:0] acc_shift;
	logic [OFFSET_BITS-1:0] room;
	logic [OFFSET_BITS-1:0] fin_room;
	logic [OFFSET_BITS-1:0] fin_len;
	logic [6:0]             count;
	logic [LEFT_W-1:0]      left_dec;
	logic                   acc_big;
	logic                   fin_fits;
	logic                   do_finish;

	assign start_pos = OFFSET_BITS'(start_offset);
	assign pos_inc   = position + OFFSET_BITS'(1);
	assign count     = byte_value[6:0];
	assign acc_shift = (length_accum << 8) | OFFSET_BITS'(byte_value);
	assign acc_big   = |length_accum[OFFSET_BITS-1 -: 8];
	assign left_dec  = (bytes_left != '0) ? bytes_left - LEFT_W'(1) : '0;
	// position never passes the limit while a header is open, so this cannot wrap
	assign room      = limit - pos_inc;

	// Both the short form and the last long-form byte finish at pos_inc
	assign fin_len   = (phase == PH_LONG) ? acc_shift : OFFSET_BITS'(byte_value);
	assign fin_room  = room;
	assign fin_fits  = (pos_inc <= limit) && (fin_len <= fin_room);

	always_comb begin
		ctl              = '{phase: phase, emit: 1'b0, ok: 1'b0, err: ERR_NONE};
		position_nxt     = position;
		held_tag_nxt     = held_tag;
		bytes_left_nxt   = bytes_left;
		length_accum_nxt = length_accum;
		res_tag          = held_tag;
		do_finish        = 1'b0;

		if (header_start) begin
			bytes_left_nxt   = '0;
			length_accum_nxt = '0;
			if (start_pos >= limit) begin
				position_nxt = start_pos;
				held_tag_nxt = '0;
				res_tag      = '0;
				ctl.emit     = 1'b1;
				ctl.err      = ERR_OFFSET;
				ctl.phase    = PH_IDLE;
			end else begin
				position_nxt = start_pos + OFFSET_BITS'(1);
				held_tag_nxt = byte_value;
				ctl.phase    = PH_FIRST;
			end
		end else begin
			case (phase)
				PH_FIRST: begin
					if (position >= limit) begin
						ctl.emit  = 1'b1;
						ctl.err   = ERR_OFFSET;
						ctl.phase = PH_IDLE;
					end else begin
						position_nxt = pos_inc;
						if (!byte_value[LONG_FORM_BIT]) begin
							do_finish = 1'b1;
						end else if (count == '0 || count > 7'(MAX_LENGTH_BYTES)) begin
							ctl.emit  = 1'b1;
							ctl.err   = ERR_COUNT;
							ctl.phase = PH_IDLE;
						end else if (OFFSET_BITS'(count) > room) begin
							ctl.emit  = 1'b1;
							ctl.err   = ERR_LENBYTES;
							ctl.phase = PH_IDLE;
						end else begin
							bytes_left_nxt   = LEFT_W'(count);
							length_accum_nxt = '0;
							ctl.phase        = PH_LONG;
						end
					end
				end
				PH_LONG: begin
					if (acc_big) begin
						ctl.emit  = 1'b1;
						ctl.err   = ERR_OVERFLOW;
						ctl.phase = PH_IDLE;
					end else begin
						length_accum_nxt = acc_shift;
						position_nxt     = pos_inc;
						bytes_left_nxt   = left_dec;
						do_finish        = (left_dec == '0);
					end
				end
				default: begin
					// drop stray bytes while idle
				end
			endcase
		end

		if (do_finish) begin
			ctl.emit  = 1'b1;
			ctl.phase = PH_IDLE;
			if (fin_fits) begin
				ctl.ok = 1'b1;
			end else begin
				ctl.err = ERR_VALUE;
			end
		end
	end

	assign res_body_offset   = ctl.ok ? pos_inc : '0;
	assign res_body_length   = ctl.ok ? fin_len : '0;
	assign res_follow_offset = ctl.ok ? pos_inc + fin_len : '0;

endmodule

/* src/der_tlv_header_parser.sv */
// DER TLV header parser: one header byte per item in, one result per header out.
//
// Channel "bytes" carries the header bytes in buffer order; the item with
// header_start set holds the tag byte and its buffer offset, and restarts the
// parser whatever it was doing. Channel "result" carries one item for each
// header that completes or fails: ok, error_code, tag and the value bounds.
// Bytes outside a header are dropped without a result.
// Registers parse_limit (index 0) and buffer_size (index 1) are written on
// wr_en; the smaller of the two bounds every check. Write them only while no
// header is in flight.
// A result item is registered: the byte that ends the header is taken into
// the input register, then its result into the result register, which
// presents it on channel result.
// Throughput: one byte per cycle while result is not stalled; the decode of
// a byte is combinational compares, a shift and adds between the two registers.
// When result is stalled the finished item holds in the result register and
// one more byte waits in the input register; bytes.ready then drops.
// Reset clears the parser to idle with both limits at all ones.
module der_tlv_header_parser #(
	parameter int OFFSET_BITS      = dtlv_pkg::OFFSET_BITS_DEF,
	parameter int MAX_LENGTH_BYTES = dtlv_pkg::MAX_LENGTH_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	dtlv_in_if.sink                          bytes,
	dtlv_out_if.source                       result,
	input  logic                             wr_en,
	input  logic [dtlv_pkg::CFG_INDEX_W-1:0] reg_index,
	input  logic [dtlv_pkg::CFG_DATA_W-1:0]  wr_data
);
	import dtlv_pkg::*;

	localparam int LEFT_W = $clog2(MAX_LENGTH_BYTES + 1);

	// input stage
	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   start_s1;
	logic [FIELD_BITS-1:0]  offset_s1;

	// parser state
	phase_t                 phase_q;
	logic [OFFSET_BITS-1:0] position_q;
	logic [7:0]             held_tag_q;
	logic [LEFT_W-1:0]      bytes_left_q;
	logic [OFFSET_BITS-1:0] length_accum_q;

	// configuration
	logic [CFG_DATA_W-1:0]  parse_limit_q;
	logic [CFG_DATA_W-1:0]  buffer_size_q;
	logic [OFFSET_BITS-1:0] limit_q;
	logic [OFFSET_BITS-1:0] wr_trunc;
	logic [OFFSET_BITS-1:0] pl_trunc;
	logic [OFFSET_BITS-1:0] bs_trunc;

	// result register
	logic                   out_valid_q;
	logic                   ok_q;
	err_t                   err_q;
	logic [7:0]             tag_q;
	logic [FIELD_BITS-1:0]  voff_q;
	logic [FIELD_BITS-1:0]  vlen_q;
	logic [FIELD_BITS-1:0]  next_q;

	step_ctl_t              ctl;
	logic [OFFSET_BITS-1:0] position_nxt;
	logic [7:0]             held_tag_nxt;
	logic [LEFT_W-1:0]      bytes_left_nxt;
	logic [OFFSET_BITS-1:0] length_accum_nxt;
	logic [7:0]             res_tag;
	logic [OFFSET_BITS-1:0] res_voff;
	logic [OFFSET_BITS-1:0] res_vlen;
	logic [OFFSET_BITS-1:0] res_next;

	logic                   out_free;
	logic                   adv;

	assign out_free    = !out_valid_q || result.ready;
	assign adv         = valid_s1 && out_free;
	assign bytes.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			byte_s1   <= bytes.byte_value;
			start_s1  <= bytes.header_start;
			offset_s1 <= bytes.start_offset;
		end
	end

	assign wr_trunc = OFFSET_BITS'(wr_data);
	assign pl_trunc = OFFSET_BITS'(parse_limit_q);
	assign bs_trunc = OFFSET_BITS'(buffer_size_q);

	// keep the effective limit precomputed so the decode path sees one register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_limit_q <= CFG_RESET_VALUE;
			buffer_size_q <= CFG_RESET_VALUE;
			limit_q       <= OFFSET_BITS'(CFG_RESET_VALUE);
		end else if (wr_en) begin
			case (reg_index)
				CFG_PARSE_LIMIT: begin
					parse_limit_q <= wr_data;
					limit_q       <= (wr_trunc < bs_trunc) ? wr_trunc : bs_trunc;
				end
				CFG_BUFFER_SIZE: begin
					buffer_size_q <= wr_data;
					limit_q       <= (pl_trunc < wr_trunc) ? pl_trunc : wr_trunc;
				end
				default: begin
					// no register at this index
				end
			endcase
		end
	end

	dtlv_step #(
		.OFFSET_BITS      (OFFSET_BITS),
		.MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
	) u_step (
		.byte_value        (byte_s1),
		.header_start      (start_s1),
		.start_offset      (offset_s1),
		.limit             (limit_q),
		.phase             (phase_q),
		.position          (position_q),
		.held_tag          (held_tag_q),
		.bytes_left        (bytes_left_q),
		.length_accum      (length_accum_q),
		.ctl               (ctl),
		.position_nxt      (position_nxt),
		.held_tag_nxt      (held_tag_nxt),
		.bytes_left_nxt    (bytes_left_nxt),
		.length_accum_nxt  (length_accum_nxt),
		.res_tag           (res_tag),
		.res_body_offset   (res_voff),
		.res_body_length   (res_vlen),
		.res_follow_offset (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			position_q     <= '0;
			held_tag_q     <= '0;
			bytes_left_q   <= '0;
			length_accum_q <= '0;
		end else if (adv) begin
			phase_q        <= ctl.phase;
			position_q     <= position_nxt;
			held_tag_q     <= held_tag_nxt;
			bytes_left_q   <= bytes_left_nxt;
			length_accum_q <= length_accum_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv && ctl.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ctl.emit) begin
			ok_q   <= ctl.ok;
			err_q  <= ctl.err;
			tag_q  <= res_tag;
			voff_q <= FIELD_BITS'(res_voff);
			vlen_q <= FIELD_BITS'(res_vlen);
			next_q <= FIELD_BITS'(res_next);
		end
	end

	assign result.valid         = out_valid_q;
	assign result.ok            = ok_q;
	assign result.error_code    = err_q;
	assign result.tag_byte      = tag_q;
	assign result.body_offset   = voff_q;
	assign result.body_length   = vlen_q;
	assign result.follow_offset = next_q;

`ifndef SYNTHESIS
	a_rise_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv && ctl.emit))
		else $error("result appeared without a finishing byte");

	a_idle_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		adv && ctl.emit |=> phase_q == PH_IDLE)
		else $error("parser not idle after emitting a result");

	a_long_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_LONG |-> bytes_left_q != '0)
		else $error("long-form phase with no length bytes left");

	a_ok_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ok_q |-> err_q == ERR_NONE && next_q == voff_q + vlen_q)
		else $error("ok result with inconsistent fields");
`endif

endmodule

/* verif/der_tlv_header_parser_tb.sv */
// Self-checking testbench of the DER TLV header parser: stimulus, prediction and result checks.
module der_tlv_header_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dtlv_pkg::*;

	localparam int          OFF_W        = OFFSET_BITS_DEF;
	localparam int          MAX_LEN_B    = MAX_LENGTH_BYTES_DEF;
	localparam logic [63:0] OFF_MASK     = {64{1'b1}} >> (64 - OFF_W);
	localparam int          LIMIT_CYCLES = 400000;
	localparam int          LONG_HOLD    = 300;
	localparam int          SETTLE       = 6;

	typedef struct {
		logic        ok;
		err_t        err;
		logic [7:0]  tag;
		logic [31:0] voff;
		logic [31:0] vlen;
		logic [31:0] noff;
	} hdr_result_t;

	class header_scoreboard;
		hdr_result_t expected_q[$];
		logic [31:0] parse_limit;
		logic [31:0] buffer_size;
		phase_t      phase;
		logic [63:0] position;
		logic [7:0]  held_tag;
		int unsigned bytes_left;
		logic [63:0] length_accum;
		int          mismatches;
		int          bytes_seen;
		int          results_seen;
		int          code_seen[8];

		function new();
			parse_limit  = CFG_RESET_VALUE;
			buffer_size  = CFG_RESET_VALUE;
			phase        = PH_IDLE;
			position     = '0;
			held_tag     = '0;
			bytes_left   = 0;
			length_accum = '0;
			mismatches   = 0;
			bytes_seen   = 0;
			results_seen = 0;
		endfunction

		function logic [63:0] limit();
			logic [63:0] a;
			logic [63:0] b;
			a = 64'(parse_limit) & OFF_MASK;
			b = 64'(buffer_size) & OFF_MASK;
			return (a < b) ? a : b;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
			if (idx == CFG_PARSE_LIMIT)
				parse_limit = val;
			else
				buffer_size = val;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// start + len <= lim, evaluated without wrapping
		function bit fits(logic [63:0] start, logic [63:0] len, logic [63:0] lim);
			return (start <= lim) && (len <= lim - start);
		endfunction

		function void push_error(err_t code, logic [7:0] tag);
			hdr_result_t r;
			r.ok   = 1'b0;
			r.err  = code;
			r.tag  = tag;
			r.voff = '0;
			r.vlen = '0;
			r.noff = '0;
			expected_q.push_back(r);
			phase = PH_IDLE;
		endfunction

		function void finish_header(logic [63:0] len, logic [63:0] lim);
			hdr_result_t r;
			if (!fits(position, len, lim)) begin
				push_error(ERR_VALUE, held_tag);
				return;
			end
			r.ok   = 1'b1;
			r.err  = ERR_NONE;
			r.tag  = held_tag;
			r.voff = position[31:0];
			r.vlen = len[31:0];
			r.noff = 32'(position + len);
			expected_q.push_back(r);
			phase = PH_IDLE;
		endfunction

		function void note_byte(logic [7:0] b, logic hs, logic [31:0] so);
			logic [63:0] lim;
			logic [63:0] count;
			lim = limit();
			bytes_seen++;
			if (hs) begin
				position     = 64'(so) & OFF_MASK;
				bytes_left   = 0;
				length_accum = '0;
				held_tag     = '0;
				if (position >= lim) begin
					push_error(ERR_OFFSET, 8'h00);
					return;
				end
				held_tag = b;
				position = position + 1;
				phase    = PH_FIRST;
				return;
			end
			case (phase)
				PH_FIRST: begin
					if (position >= lim) begin
						push_error(ERR_OFFSET, held_tag);
						return;
					end
					position = position + 1;
					if (!b[LONG_FORM_BIT]) begin
						finish_header(64'(b), lim);
						return;
					end
					count = 64'(b[6:0]);
					if (count == 0 || count > MAX_LEN_B) begin
						push_error(ERR_COUNT, held_tag);
						return;
					end
					if (!fits(position, count, lim)) begin
						push_error(ERR_LENBYTES, held_tag);
						return;
					end
					bytes_left   = int'(count);
					length_accum = '0;
					phase        = PH_LONG;
				end
				PH_LONG: begin
					if (length_accum > (OFF_MASK >> 8)) begin
						push_error(ERR_OVERFLOW, held_tag);
						return;
					end
					length_accum = ((length_accum << 8) | 64'(b)) & OFF_MASK;
					position     = position + 1;
					if (bytes_left > 0)
						bytes_left--;
					if (bytes_left == 0)
						finish_header(length_accum, lim);
				end
				default: ;
			endcase
		endfunction

		function void compare(string field, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(hdr_result_t got);
			hdr_result_t want;
			results_seen++;
			if (!$isunknown(got.err))
				code_seen[got.err]++;
			if (expected_q.size() == 0) begin
				$display("%0t: result with nothing expected: expected none, actual ok=%0b err=%0d tag=%0h",
					$time, got.ok, got.err, got.tag);
				mismatches++;
				return;
			end
			want = expected_q.pop_front();
			compare("ok", 64'(want.ok), 64'(got.ok));
			compare("error_code", 64'(want.err), 64'(got.err));
			compare("tag_byte", 64'(want.tag), 64'(got.tag));
			compare("body_offset", 64'(want.voff), 64'(got.voff));
			compare("body_length", 64'(want.vlen), 64'(got.vlen));
			compare("follow_offset", 64'(want.noff), 64'(got.noff));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [CFG_INDEX_W-1:0] reg_index;
	logic [CFG_DATA_W-1:0]  wr_data;

	dtlv_in_if  bytes_if();
	dtlv_out_if result_if();

	der_tlv_header_parser uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.bytes     (bytes_if),
		.result    (result_if),
		.wr_en     (wr_en),
		.reg_index (reg_index),
		.wr_data   (wr_data)
	);

	header_scoreboard sb = new();

	int burst_left = 0;
	int cycles = 0;
	int settings_run = 0;
	bit hold_req = 0;
	int holds_done = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results still expected", cycles, sb.pending());
			$display("der_tlv_header_parser_tb: FAIL");
			$finish;
		end
	end

	// sample both channels at the edge
	always @(posedge clk) begin
		hdr_result_t got;
		if (result_if.valid && result_if.ready) begin
			got.ok   = result_if.ok;
			got.err  = err_t'(result_if.error_code);
			got.tag  = result_if.tag_byte;
			got.voff = result_if.body_offset;
			got.vlen = result_if.body_length;
			got.noff = result_if.follow_offset;
			sb.check_result(got);
		end
		if (bytes_if.valid && bytes_if.ready)
			sb.note_byte(bytes_if.byte_value, bytes_if.header_start, bytes_if.start_offset);
	end

	initial begin : receiver
		int seg;
		int mode;
		seg  = 0;
		mode = 0;
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				// hold off long enough for the input side to back up
				result_if.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 0;
				holds_done++;
			end else begin
				if (seg == 0) begin
					seg  = $urandom_range(10, 80);
					mode = $urandom_range(0, 3);
				end
				seg--;
				case (mode)
					0: result_if.ready <= 1'b1;
					1: result_if.ready <= 1'($urandom_range(0, 1));
					2: result_if.ready <= ($urandom_range(0, 4) != 0);
					default: result_if.ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	task automatic put_byte(input logic [7:0] b, input logic hs, input logic [31:0] so);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				bytes_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		bytes_if.valid        <= 1'b1;
		bytes_if.byte_value   <= b;
		bytes_if.header_start <= hs;
		bytes_if.start_offset <= so;
		do @(posedge clk); while (!bytes_if.ready);
	endtask

	// close any header in progress so the parser ends idle, then let results drain
	task automatic close_and_drain();
		put_byte(8'($urandom), 1'b1, 32'd0);
		put_byte(8'h00, 1'b0, $urandom);
		bytes_if.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_limits(input logic [31:0] plim, input logic [31:0] bsize);
		wr_en     <= 1'b1;
		reg_index <= CFG_PARSE_LIMIT;
		wr_data   <= plim;
		@(posedge clk);
		reg_index <= CFG_BUFFER_SIZE;
		wr_data   <= bsize;
		@(posedge clk);
		wr_en <= 1'b0;
		sb.write_reg(CFG_PARSE_LIMIT, plim);
		sb.write_reg(CFG_BUFFER_SIZE, bsize);
		settings_run++;
	endtask

	task automatic random_header(inout int sent);
		logic [63:0] lim;
		logic [31:0] off;
		logic [7:0]  v;
		int cnt;
		int stop;
		int form;
		bit zeros;
		lim = sb.limit();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: off = $urandom_range(0, 200);
			4: off = (lim > 8) ? 32'(lim - $urandom_range(0, 8)) : $urandom_range(0, 8);
			5: off = 32'hFFFF_FFFF - $urandom_range(0, 8);
			6: off = $urandom;
			default: off = $urandom_range(0, 40);
		endcase
		put_byte(8'($urandom), 1'b1, off);
		sent++;
		form = $urandom_range(0, 19);
		if (form < 8) begin
			put_byte(8'($urandom_range(0, 127)), 1'b0, $urandom);
			sent++;
		end else if (form < 15) begin
			cnt = $urandom_range(1, MAX_LEN_B);
			v = 8'h80 | 8'(cnt);
			put_byte(v, 1'b0, $urandom);
			sent++;
			// now and then cut the length short; the next tag restarts
			stop  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, cnt - 1) : cnt;
			zeros = 1'($urandom_range(0, 1));
			for (int i = 0; i < stop; i++) begin
				v = (zeros && i < cnt - 1) ? 8'h00 : 8'($urandom);
				put_byte(v, 1'b0, $urandom);
				sent++;
			end
		end else if (form < 18) begin
			v = $urandom_range(0, 1) ? 8'h80 : (8'h80 | 8'($urandom_range(MAX_LEN_B + 1, 127)));
			put_byte(v, 1'b0, $urandom);
			sent++;
		end else if (form == 18) begin
			repeat ($urandom_range(1, 3)) begin
				put_byte(8'($urandom), 1'b0, $urandom);
				sent++;
			end
		end
	endtask

	task automatic random_phase(input int n, input bit with_hold);
		int sent;
		sent = 0;
		if (with_hold)
			hold_req = 1;
		while (sent < n) begin
			if ($urandom_range(0, 9) == 0)
				put_byte(8'($urandom), 1'b0, $urandom);
			random_header(sent);
		end
		close_and_drain();
	endtask

	initial begin
		arst_n                <= 1'b0;
		wr_en                 <= 1'b0;
		reg_index             <= CFG_PARSE_LIMIT;
		wr_data               <= '0;
		bytes_if.valid        <= 1'b0;
		bytes_if.byte_value   <= '0;
		bytes_if.header_start <= 1'b0;
		bytes_if.start_offset <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed headers at the reset limits
		put_byte(8'hFF, 1'b1, 32'd0);           put_byte(8'h7F, 1'b0, $urandom);
		put_byte(8'h00, 1'b1, 32'hFFFF_FFFF);
		put_byte(8'h04, 1'b1, 32'd0);           put_byte(8'h84, 1'b0, $urandom);
		repeat (4) put_byte(8'hFF, 1'b0, $urandom);
		put_byte(8'hA0, 1'b1, 32'hFFFF_FFFE);   put_byte(8'h01, 1'b0, $urandom);
		put_byte(8'h31, 1'b1, 32'd0);           put_byte(8'h80, 1'b0, $urandom);
		put_byte(8'h31, 1'b1, 32'd0);           put_byte(8'h85, 1'b0, $urandom);
		put_byte(8'h31, 1'b1, 32'hFFFF_FFFC);   put_byte(8'h84, 1'b0, $urandom);
		put_byte(8'h55, 1'b0, $urandom);
		put_byte(8'h10, 1'b1, 32'd5);           put_byte(8'h82, 1'b0, $urandom);
		put_byte(8'h01, 1'b0, $urandom);
		put_byte(8'h17, 1'b1, 32'd7);           put_byte(8'h00, 1'b0, $urandom);
		put_byte(8'h66, 1'b1, 32'hFFFF_FFF0);   put_byte(8'h7F, 1'b0, $urandom);
		close_and_drain();

		random_phase(125, 1'b0);
		set_limits(32'd0, 32'hFFFF_FFFF);
		random_phase(35, 1'b0);
		set_limits(32'hFFFF_FFFF, 32'd0);
		random_phase(25, 1'b0);
		set_limits(32'd300, 32'd1000);
		random_phase(145, 1'b1);
		set_limits(32'd5000, 32'd260);
		random_phase(145, 1'b0);
		set_limits($urandom_range(16, 400), $urandom);
		random_phase(125, 1'b1);
		set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		random_phase(125, 1'b0);

		$display("covered %0d header bytes and %0d results over %0d limit settings, %0d long stalls",
			sb.bytes_seen, sb.results_seen, settings_run + 1, holds_done);
		$display("results by code: ok %0d, offset %0d, count %0d, length bytes %0d, value %0d",
			sb.code_seen[ERR_NONE], sb.code_seen[ERR_OFFSET], sb.code_seen[ERR_COUNT],
			sb.code_seen[ERR_LENBYTES], sb.code_seen[ERR_VALUE]);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("der_tlv_header_parser_tb: PASS");
		else
			$display("der_tlv_header_parser_tb: FAIL");
		$finish;
	end
endmodule
